@@ sv/grid_trilinear_interpolator_macros.svh @@
// ---------------------------------------------------------------------------
// Grid trilinear interpolator assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GRID_TRILINEAR_INTERPOLATOR_MACROS_SVH
`define GRID_TRILINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define GTI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gti_pkg.sv @@
// ---------------------------------------------------------------------------
// Grid trilinear interpolator package
// Shared widths, transaction payload types and opcodes.
// ---------------------------------------------------------------------------
`default_nettype none

package gti_pkg;

  localparam int MAX_GRID_DIM = 16;
  localparam int MAX_VERTICES = 4096;
  localparam int COORD_WIDTH  = 32;

  localparam int VIDX_W    = $clog2(MAX_VERTICES);
  localparam int DIM_W     = 5;
  localparam int CELL_W    = $clog2(MAX_GRID_DIM);
  localparam int QRY_W     = 16;
  localparam int WIN_W     = 2 * QRY_W;
  localparam int CFG_IDX_W = 3;
  localparam int Q_FRAC    = 14;               // Q2.14 fraction bits
  localparam int U_FRAC    = 2 * Q_FRAC;       // mapped coordinate fraction bits
  localparam int U_W       = 34;
  localparam int X_W       = 38;
  localparam int FRAC_W    = X_W - Q_FRAC;
  localparam int LERP_W    = COORD_WIDTH + 8;
  localparam int VERT_W    = 3 * COORD_WIDTH;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_I,
    REG_GRID_J,
    REG_GRID_K,
    REG_WINDOW_R,
    REG_WINDOW_S,
    REG_WINDOW_T
  } cfg_reg_t;

  typedef struct packed {
    logic                          opcode;
    logic [VIDX_W-1:0]             vertex_index;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;
    logic signed [QRY_W-1:0]       query_r;
    logic signed [QRY_W-1:0]       query_s;
    logic signed [QRY_W-1:0]       query_t;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } result_t;

  typedef logic signed [LERP_W-1:0] lerp_t;
  typedef logic signed [FRAC_W-1:0] frac_t;

endpackage

`default_nettype wire

@@ sv/gti_locate.sv @@
// ---------------------------------------------------------------------------
// Axis locator
// Maps one parametric coordinate into its window, scales by the grid span
// and splits it into a clamped cell index and a Q.14 local fraction.
// Four register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module gti_locate (
  input  logic                           clk,
  input  logic [gti_pkg::WIN_W-1:0]      window,
  input  logic signed [gti_pkg::QRY_W-1:0] q,
  input  logic [gti_pkg::DIM_W-1:0]      n,
  output logic [gti_pkg::CELL_W-1:0]     cell_idx,
  output gti_pkg::frac_t                 frac
);
  import gti_pkg::*;

  localparam int PROD_W  = 2 * QRY_W + 1;
  localparam int WHOLE_W = X_W - 1 - U_FRAC;

  logic signed [QRY_W-1:0]  w_start;
  logic signed [QRY_W-1:0]  w_end;
  logic signed [QRY_W:0]    span;
  logic signed [PROD_W-1:0] prod;
  logic signed [U_W-1:0]    u;
  logic signed [U_W-1:0]    u_next;
  logic [CELL_W-1:0]        nm1;
  logic [CELL_W-1:0]        cap;
  logic signed [X_W-1:0]    x;
  logic signed [X_W-1:0]    x_next;
  logic signed [X_W-1:0]    xc;
  logic [CELL_W-1:0]        cell_c;
  logic [CELL_W-1:0]        cell_c_next;
  logic [WHOLE_W-1:0]       whole;
  logic signed [X_W-1:0]    loc;
  logic signed [X_W-1:0]    rnd;

  assign w_start = window[WIN_W-1 -: QRY_W];
  assign w_end   = window[QRY_W-1:0];
  assign nm1     = CELL_W'(n - DIM_W'(1));
  assign cap     = CELL_W'(n - DIM_W'(2));

  // u = start + (end - start) * q, Q.28
  always_comb begin
    span   = (QRY_W + 1)'(w_end) - (QRY_W + 1)'(w_start);
    prod   = PROD_W'(span) * PROD_W'(q);
    u_next = (U_W'(w_start) <<< Q_FRAC) + U_W'(prod);
  end

  assign x_next = X_W'(u) * X_W'(signed'({1'b0, nm1}));

  // integer part, clamped to [0, n-2]
  always_comb begin
    whole = x[X_W-2:U_FRAC];
    if (x[X_W-1] || (x == '0)) begin
      cell_c_next = '0;
    end else if (whole > WHOLE_W'(cap)) begin
      cell_c_next = cap;
    end else begin
      cell_c_next = whole[CELL_W-1:0];
    end
  end

  // local fraction rounded half up to Q.14
  always_comb begin
    loc = xc - (X_W'(cell_c) <<< U_FRAC);
    rnd = loc + X_W'(1 << (Q_FRAC - 1));
  end

  always_ff @(posedge clk) begin
    u        <= u_next;
    x        <= x_next;
    xc       <= x;
    cell_c   <= cell_c_next;
    cell_idx <= cell_c;
    frac     <= rnd[X_W-1:Q_FRAC];
  end

endmodule

`default_nettype wire

@@ sv/gti_lerp.sv @@
// ---------------------------------------------------------------------------
// Linear blend step
// y = sat(a + round(f * (b - a))), rounding half away from zero.
// Three register stages: magnitude, multiply, round/add/saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module gti_lerp (
  input  logic           clk,
  input  gti_pkg::lerp_t a,
  input  gti_pkg::lerp_t b,
  input  gti_pkg::frac_t f,
  output gti_pkg::lerp_t y
);
  import gti_pkg::*;

  localparam int MAG_W  = LERP_W + 1;
  localparam int PROD_W = MAG_W + FRAC_W;
  localparam int SUM_W  = PROD_W - Q_FRAC + 2;

  logic signed [MAG_W-1:0] d;
  logic [MAG_W-1:0]        md1;
  logic [FRAC_W-1:0]       mf1;
  logic                    neg1;
  lerp_t                   a1;
  logic [PROD_W-1:0]       prod2;
  logic                    neg2;
  lerp_t                   a2;
  logic [PROD_W-1:0]       rnd;
  logic signed [SUM_W-1:0] qs;
  logic signed [SUM_W-1:0] sum;
  lerp_t                   y_next;

  assign d = MAG_W'(b) - MAG_W'(a);

  always_comb begin
    rnd = prod2 + PROD_W'(1 << (Q_FRAC - 1));
    qs  = signed'(SUM_W'(rnd >> Q_FRAC));
    sum = SUM_W'(a2) + (neg2 ? -qs : qs);
    if ((&sum[SUM_W-1:LERP_W-1]) || !(|sum[SUM_W-1:LERP_W-1])) begin
      y_next = sum[LERP_W-1:0];
    end else if (sum[SUM_W-1]) begin
      y_next = {1'b1, {(LERP_W - 1){1'b0}}};
    end else begin
      y_next = {1'b0, {(LERP_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    a1    <= a;
    md1   <= d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    mf1   <= f[FRAC_W-1] ? FRAC_W'(-f) : FRAC_W'(f);
    neg1  <= d[MAG_W-1] ^ f[FRAC_W-1];
    a2    <= a1;
    prod2 <= PROD_W'(md1) * PROD_W'(mf1);
    neg2  <= neg1;
    y     <= y_next;
  end

endmodule

`default_nettype wire

@@ sv/grid_trilinear_interpolator.sv @@
// ---------------------------------------------------------------------------
// Grid trilinear interpolator (top level)
// Vertex grid store with a fully pipelined trilinear query path.
// ---------------------------------------------------------------------------
// Usage:
//  - Command channel: a transaction is taken on a rising edge with start high
//    and busy low. opcode OP_LOAD writes one vertex at vertex_index,
//    OP_QUERY evaluates the point at query_r/s/t.
//  - Throughput: one transaction per clock while busy is low, loads and queries
//    mixed freely. Every pipeline stage advances each cycle; busy is low except
//    during reset and in the cycle after it.
//  - Result: a query's result shows on result with done high for exactly
//    one cycle, after the locate, address, store read, blend and output stages.
//    Loads give no result. Results come back in query order.
//  - The receiver cannot stall; done is a strobe and nothing is held back.
//  - Config port: cfg_valid/cfg_ready write register cfg_index with
//    cfg_data. Write only while no query is in flight.
//  - Reset (sync, active high) clears control, config and the valid chain.
//    The vertex store is not cleared: read only vertices already loaded.
//  - Rate is set by the eight store copies, one read port per cell corner,
//    plus 21 three-stage blend units (7 per axis).
// ---------------------------------------------------------------------------
`default_nettype none

`include "grid_trilinear_interpolator_macros.svh"

module grid_trilinear_interpolator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  gti_pkg::cmd_t                 cmd,
  output logic                          done,
  output gti_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gti_pkg::WIN_W-1:0]     cfg_data
);
  import gti_pkg::*;

  localparam int KJ_W      = 2 * CELL_W;
  localparam int LD_DEPTH  = 6;   // s0 to store-write stage
  localparam int QV_DEPTH  = 16;  // locate..last blend stage
  localparam int ST_F      = 5;   // stage that addresses the store
  localparam int ST_LOC    = 3;   // locator outputs valid

  typedef struct packed {
    logic              valid;
    logic [VIDX_W-1:0] index;
    logic [VERT_W-1:0] data;
  } load_t;

  // configuration
  logic [DIM_W-1:0] grid_i, grid_j, grid_k;
  logic [WIN_W-1:0] window_r, window_s, window_t;
  logic [DIM_W-1:0] ni, nj, nk;
  logic [VIDX_W-1:0] plane;

  // input stage
  cmd_t cmd_q;
  logic s0_query;
  logic s0_load;

  load_t ld_pipe [LD_DEPTH];
  logic [QV_DEPTH-1:0] qv;

  // locate outputs
  logic [CELL_W-1:0] cell_i, cell_j, cell_k;
  frac_t fr, fs, ft;
  frac_t fr_d [3];
  frac_t fs_d [6];
  frac_t ft_d [9];

  // address stages
  logic [KJ_W-1:0]   kj;
  logic [CELL_W-1:0] ci_e;
  logic [VIDX_W-1:0] base;
  logic [VIDX_W-1:0] addr [8];
  logic [VERT_W-1:0] rdata [8];

  // blend tree
  lerp_t corner_val [3][8];
  lerp_t l1 [3][4];
  lerp_t l2 [3][2];
  lerp_t l3 [3];

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] n);
    if (n < DIM_W'(2)) begin
      return DIM_W'(2);
    end else if (n > DIM_W'(MAX_GRID_DIM)) begin
      return DIM_W'(MAX_GRID_DIM);
    end
    return n;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input lerp_t v);
    if ((&v[LERP_W-1:COORD_WIDTH-1]) || !(|v[LERP_W-1:COORD_WIDTH-1])) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[LERP_W-1]) begin
      return {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    end
    return {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  endfunction

  assign ni    = clamp_dim(grid_i);
  assign nj    = clamp_dim(grid_j);
  assign nk    = clamp_dim(grid_k);
  assign plane = VIDX_W'(ni) * VIDX_W'(nj);

  assign cfg_ready = !busy;

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      grid_i   <= DIM_W'(2);
      grid_j   <= DIM_W'(2);
      grid_k   <= DIM_W'(2);
      window_r <= WIN_W'(1 << Q_FRAC);
      window_s <= WIN_W'(1 << Q_FRAC);
      window_t <= WIN_W'(1 << Q_FRAC);
      s0_query <= 1'b0;
      s0_load  <= 1'b0;
      qv       <= '0;
      done     <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s0_query <= start && !busy && (cmd.opcode == OP_QUERY);
      s0_load  <= start && !busy && (cmd.opcode == OP_LOAD);
      qv       <= {qv[QV_DEPTH-2:0], s0_query};
      done     <= qv[QV_DEPTH-1];
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_I:   grid_i   <= cfg_data[DIM_W-1:0];
          REG_GRID_J:   grid_j   <= cfg_data[DIM_W-1:0];
          REG_GRID_K:   grid_k   <= cfg_data[DIM_W-1:0];
          REG_WINDOW_R: window_r <= cfg_data;
          REG_WINDOW_S: window_s <= cfg_data;
          REG_WINDOW_T: window_t <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload of the input stage
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  // Loads ride along to the store stage so every access hits the store in
  // transaction order.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LD_DEPTH; s++) begin
        ld_pipe[s].valid <= 1'b0;
      end
    end else begin
      ld_pipe[0].valid <= s0_load;
      for (int s = 1; s < LD_DEPTH; s++) begin
        ld_pipe[s].valid <= ld_pipe[s-1].valid;
      end
    end
    ld_pipe[0].index <= cmd_q.vertex_index;
    ld_pipe[0].data  <= {cmd_q.vertex_z, cmd_q.vertex_y, cmd_q.vertex_x};
    for (int s = 1; s < LD_DEPTH; s++) begin
      ld_pipe[s].index <= ld_pipe[s-1].index;
      ld_pipe[s].data  <= ld_pipe[s-1].data;
    end
  end

  // per-axis cell and fraction
  gti_locate u_loc_r (
    .clk(clk), .window(window_r), .q(cmd_q.query_r), .n(ni),
    .cell_idx(cell_i), .frac(fr)
  );
  gti_locate u_loc_s (
    .clk(clk), .window(window_s), .q(cmd_q.query_s), .n(nj),
    .cell_idx(cell_j), .frac(fs)
  );
  gti_locate u_loc_t (
    .clk(clk), .window(window_t), .q(cmd_q.query_t), .n(nk),
    .cell_idx(cell_k), .frac(ft)
  );

  // fractions wait for their blend level
  always_ff @(posedge clk) begin
    fr_d[0] <= fr;
    fs_d[0] <= fs;
    ft_d[0] <= ft;
    for (int s = 1; s < 3; s++) fr_d[s] <= fr_d[s-1];
    for (int s = 1; s < 6; s++) fs_d[s] <= fs_d[s-1];
    for (int s = 1; s < 9; s++) ft_d[s] <= ft_d[s-1];
  end

  // base vertex index: (k*nj + j)*ni + i
  always_ff @(posedge clk) begin
    kj   <= KJ_W'(cell_k) * KJ_W'(nj) + KJ_W'(cell_j);
    ci_e <= cell_i;
    base <= VIDX_W'(kj) * VIDX_W'(ni) + VIDX_W'(ci_e);
  end

  // Eight store copies, one per cell corner; corner bit 0 = +i, 1 = +j, 2 = +k.
  for (genvar c = 0; c < 8; c++) begin : g_bank
    logic [VERT_W-1:0] mem [MAX_VERTICES];

    assign addr[c] = base + VIDX_W'(c & 1)
                   + (((c >> 1) & 1) != 0 ? VIDX_W'(ni) : '0)
                   + (((c >> 2) & 1) != 0 ? plane : '0);

    always_ff @(posedge clk) begin
      if (ld_pipe[LD_DEPTH-1].valid) begin
        mem[ld_pipe[LD_DEPTH-1].index] <= ld_pipe[LD_DEPTH-1].data;
      end
      rdata[c] <= mem[addr[c]];
    end

    for (genvar ax = 0; ax < 3; ax++) begin : g_ax
      assign corner_val[ax][c] =
        LERP_W'(signed'(rdata[c][ax*COORD_WIDTH +: COORD_WIDTH]));
    end
  end

  // blend along i, then j, then k
  for (genvar ax = 0; ax < 3; ax++) begin : g_blend
    for (genvar p = 0; p < 4; p++) begin : g_l1
      gti_lerp u_l1 (
        .clk(clk), .a(corner_val[ax][2*p]), .b(corner_val[ax][2*p+1]),
        .f(fr_d[2]), .y(l1[ax][p])
      );
    end
    for (genvar p = 0; p < 2; p++) begin : g_l2
      gti_lerp u_l2 (
        .clk(clk), .a(l1[ax][2*p]), .b(l1[ax][2*p+1]),
        .f(fs_d[5]), .y(l2[ax][p])
      );
    end
    gti_lerp u_l3 (
      .clk(clk), .a(l2[ax][0]), .b(l2[ax][1]), .f(ft_d[8]), .y(l3[ax])
    );
  end

  always_ff @(posedge clk) begin
    result.point_x <= sat_coord(l3[0]);
    result.point_y <= sat_coord(l3[1]);
    result.point_z <= sat_coord(l3[2]);
  end

  // checks
  `GTI_ASSERT_IMPL(a_done_latency, done, $past(start && !busy && !rst && (cmd.opcode == OP_QUERY), 18), "result strobe without matching query")
  `GTI_ASSERT_IMPL(a_store_port, qv[ST_F], !ld_pipe[LD_DEPTH-1].valid, "load and query collide at store")
  `GTI_ASSERT_IMPL(a_cell_range, qv[ST_LOC], (cell_i <= CELL_W'(ni - DIM_W'(2))) && (cell_k <= CELL_W'(nk - DIM_W'(2))), "cell index past grid edge")

endmodule

`default_nettype wire
